FILE: sv/dltq_pkg.sv
package dltq_pkg;

    // sizing
    localparam int SLOTS      = 16;
    localparam int DELAY_BITS = 32;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int ID_W       = 4;
    localparam int TICK_W     = 32;
    localparam int CMDQ_DEPTH = 2;
    localparam int RSPQ_DEPTH = 4;

    // operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE        = 2'd0;
    localparam logic [1:0] ST_ADD_REFUSED = 2'd1;
    localparam logic [1:0] ST_REM_REFUSED = 2'd2;
    localparam logic [1:0] ST_EXPIRED     = 2'd3;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_NOP    = 2'd3
    } dltq_kind_t;

    typedef struct packed {
        logic [1:0]      operation;
        logic [ID_W-1:0] event_id;
        logic [31:0]     delay;
    } dltq_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   expired_id;
        logic [TICK_W-1:0] tick_count;
        logic              last;
    } dltq_rsp_t;

    // classified command between front and back
    typedef struct packed {
        dltq_kind_t            kind;
        logic                  id_ok;
        logic [SLOT_W-1:0]     slot;
        logic [DELAY_BITS-1:0] delay;
    } dltq_cmd_t;

endpackage

FILE: sv/dltq_front.sv
module dltq_front
    import dltq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  dltq_req_t req,
    output logic      cmd_valid,
    input  logic      cmd_take,
    output dltq_cmd_t cmd
);

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int QC_W  = $clog2(CMDQ_DEPTH + 1);

    dltq_cmd_t         q_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next, rd_reg, rd_next;
    logic [QC_W-1:0]   cnt_reg, cnt_next;
    dltq_cmd_t         cls;
    logic              do_push, do_pop;

    // classify the request
    always_comb
    begin
        cls.id_ok = (32'(req.event_id) < 32'(SLOTS));
        cls.slot  = SLOT_W'(req.event_id);
        cls.delay = DELAY_BITS'(req.delay);
        unique case (req.operation)
            OP_ADD:    cls.kind = KIND_ADD;
            OP_REMOVE: cls.kind = KIND_REMOVE;
            OP_TICK:   cls.kind = KIND_TICK;
            default:   cls.kind = KIND_NOP;
        endcase
    end

    assign full      = (cnt_reg == QC_W'(CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    // pointer update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= cls;
        end
    end

endmodule

FILE: sv/dltq_result_q.sv
module dltq_result_q
    import dltq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_valid,
    input  dltq_rsp_t res,
    output logic      res_full,
    output logic      empty,
    input  logic      pop,
    output dltq_rsp_t rsp
);

    localparam int PTR_W = $clog2(RSPQ_DEPTH);
    localparam int QC_W  = $clog2(RSPQ_DEPTH + 1);

    dltq_rsp_t        q_reg [RSPQ_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [QC_W-1:0]  cnt_reg;
    logic             do_push, do_pop;

    assign res_full = (cnt_reg == QC_W'(RSPQ_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign rsp      = q_reg[rd_reg];
    assign do_push  = res_valid && !res_full;
    assign do_pop   = pop && !empty;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PTR_W'(RSPQ_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(RSPQ_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= res;
        end
    end

endmodule

FILE: sv/dltq_engine.sv
module dltq_engine
    import dltq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_take,
    input  dltq_cmd_t cmd,
    output logic      res_valid,
    output dltq_rsp_t res,
    input  logic      res_full
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADD  = 4'b0010,
        S_REM  = 4'b0100,
        S_TICK = 4'b1000
    } state_t;

    state_t                state_reg, state_next;

    // slot store
    logic [DELAY_BITS-1:0] delta_reg [SLOTS];
    logic [SLOT_W-1:0]     link_reg  [SLOTS];
    logic [SLOTS-1:0]      pending_reg, pending_next;
    logic [SLOT_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;

    // walk context
    logic [SLOT_W-1:0]     id_reg, id_next;
    logic [DELAY_BITS-1:0] d_reg, d_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [SLOT_W-1:0]     pred_reg, pred_next;
    logic                  has_pred_reg, has_pred_next;
    logic [DELAY_BITS-1:0] curr_reg, curr_next;
    logic [CNT_W-1:0]      i_reg, i_next;
    logic                  t_reg, t_next;

    // write ports
    logic                  wa_en, wb_en, la_en, lb_en;
    logic [SLOT_W-1:0]     wa_addr, wb_addr, la_addr, lb_addr;
    logic [DELAY_BITS-1:0] wa_data, wb_data;
    logic [SLOT_W-1:0]     la_data, lb_data;

    // helpers
    logic [DELAY_BITS-1:0] sum, nd, dh, dn;
    logic [SLOT_W-1:0]     nx;
    logic                  expire, t_after, more;

    assign sum = curr_reg + delta_reg[cur_reg];
    assign nd  = d_reg - curr_reg;
    assign dh  = delta_reg[head_reg];
    assign nx  = link_reg[head_reg];
    assign dn  = delta_reg[nx];
    assign expire  = (count_reg != '0) &&
                     ((dh == '0) || ((dh == DELAY_BITS'(1)) && t_reg));
    assign t_after = t_reg && (dh == '0);
    assign more    = (count_reg > CNT_W'(1)) &&
                     ((dn == '0) || ((dn == DELAY_BITS'(1)) && t_after));

    always_comb
    begin
        state_next    = state_reg;
        pending_next  = pending_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        tick_next     = tick_reg;
        id_next       = id_reg;
        d_next        = d_reg;
        cur_next      = cur_reg;
        pred_next     = pred_reg;
        has_pred_next = has_pred_reg;
        curr_next     = curr_reg;
        i_next        = i_reg;
        t_next        = t_reg;
        cmd_take      = 1'b0;
        res_valid     = 1'b0;
        res.status     = ST_DONE;
        res.expired_id = '0;
        res.tick_count = tick_reg;
        res.last       = 1'b1;
        wa_en = 1'b0; wa_addr = '0; wa_data = '0;
        wb_en = 1'b0; wb_addr = '0; wb_data = '0;
        la_en = 1'b0; la_addr = '0; la_data = '0;
        lb_en = 1'b0; lb_addr = '0; lb_data = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    // common walk start
                    id_next       = cmd.slot;
                    d_next        = cmd.delay;
                    cur_next      = head_reg;
                    has_pred_next = 1'b0;
                    curr_next     = '0;
                    i_next        = '0;
                    unique case (cmd.kind)
                        KIND_ADD:
                        begin
                            if (!cmd.id_ok || pending_reg[cmd.slot])
                            begin
                                if (!res_full)
                                begin
                                    cmd_take   = 1'b1;
                                    res_valid  = 1'b1;
                                    res.status = ST_ADD_REFUSED;
                                end
                            end
                            else
                            begin
                                cmd_take   = 1'b1;
                                state_next = S_ADD;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (!cmd.id_ok || !pending_reg[cmd.slot])
                            begin
                                if (!res_full)
                                begin
                                    cmd_take   = 1'b1;
                                    res_valid  = 1'b1;
                                    res.status = ST_REM_REFUSED;
                                end
                            end
                            else
                            begin
                                cmd_take   = 1'b1;
                                state_next = S_REM;
                            end
                        end
                        KIND_TICK:
                        begin
                            cmd_take   = 1'b1;
                            tick_next  = tick_reg + 1'b1;
                            t_next     = 1'b1;
                            state_next = S_TICK;
                        end
                        default:
                        begin
                            if (!res_full)
                            begin
                                cmd_take  = 1'b1;
                                res_valid = 1'b1;
                            end
                        end
                    endcase
                end
            end

            S_ADD:
            begin
                // walk until the new deadline falls before the running sum
                if (i_reg == count_reg || d_reg < sum)
                begin
                    if (!res_full)
                    begin
                        res_valid = 1'b1;
                        wa_en     = 1'b1;
                        wa_addr   = id_reg;
                        wa_data   = nd;
                        la_en     = 1'b1;
                        la_addr   = id_reg;
                        if (i_reg != count_reg)
                        begin
                            wb_en   = 1'b1;
                            wb_addr = cur_reg;
                            wb_data = delta_reg[cur_reg] - nd;
                            la_data = cur_reg;
                        end
                        if (has_pred_reg)
                        begin
                            lb_en   = 1'b1;
                            lb_addr = pred_reg;
                            lb_data = id_reg;
                        end
                        else
                        begin
                            head_next = id_reg;
                        end
                        pending_next[id_reg] = 1'b1;
                        count_next = count_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    curr_next     = sum;
                    pred_next     = cur_reg;
                    has_pred_next = 1'b1;
                    cur_next      = link_reg[cur_reg];
                    i_next        = i_reg + 1'b1;
                end
            end

            S_REM:
            begin
                if (i_reg == count_reg || cur_reg == id_reg)
                begin
                    if (!res_full)
                    begin
                        res_valid = 1'b1;
                        if (i_reg != count_reg)
                        begin
                            // hand the delta to the successor and unlink
                            if (i_reg + 1'b1 < count_reg)
                            begin
                                wa_en   = 1'b1;
                                wa_addr = link_reg[id_reg];
                                wa_data = delta_reg[link_reg[id_reg]] + delta_reg[id_reg];
                            end
                            if (has_pred_reg)
                            begin
                                lb_en   = 1'b1;
                                lb_addr = pred_reg;
                                lb_data = link_reg[id_reg];
                            end
                            else
                            begin
                                head_next = link_reg[id_reg];
                            end
                        end
                        pending_next[id_reg] = 1'b0;
                        count_next = count_reg - 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    pred_next     = cur_reg;
                    has_pred_next = 1'b1;
                    cur_next      = link_reg[cur_reg];
                    i_next        = i_reg + 1'b1;
                end
            end

            S_TICK:
            begin
                if (!res_full)
                begin
                    res_valid = 1'b1;
                    if (expire)
                    begin
                        // report the head and look one slot ahead for last
                        res.status     = ST_EXPIRED;
                        res.expired_id = ID_W'(head_reg);
                        res.last       = !more;
                        pending_next[head_reg] = 1'b0;
                        head_next  = nx;
                        count_next = count_reg - 1'b1;
                        t_next     = t_after;
                        if (!more)
                        begin
                            if (count_reg > CNT_W'(1))
                            begin
                                wa_en   = 1'b1;
                                wa_addr = nx;
                                wa_data = dn - DELAY_BITS'(t_after);
                            end
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        // nothing due on this tick
                        if (count_reg != '0)
                        begin
                            wa_en   = 1'b1;
                            wa_addr = head_reg;
                            wa_data = dh - DELAY_BITS'(t_reg);
                        end
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pending_reg <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            tick_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            tick_reg    <= tick_next;
        end
    end

    // walk context and slot store
    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        d_reg        <= d_next;
        cur_reg      <= cur_next;
        pred_reg     <= pred_next;
        has_pred_reg <= has_pred_next;
        curr_reg     <= curr_next;
        i_reg        <= i_next;
        t_reg        <= t_next;
        if (wa_en)
        begin
            delta_reg[wa_addr] <= wa_data;
        end
        if (wb_en)
        begin
            delta_reg[wb_addr] <= wb_data;
        end
        if (la_en)
        begin
            link_reg[la_addr] <= la_data;
        end
        if (lb_en)
        begin
            link_reg[lb_addr] <= lb_data;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("queued count beyond slot count");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !res_full)
        else $error("result issued into a full queue");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD || state_reg == S_REM) |-> (i_reg <= count_reg))
        else $error("list walk ran past the queued count");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'($countones(pending_reg)) == count_reg)
        else $error("queued count disagrees with pending bits");
`endif

endmodule

FILE: sv/delta_list_timer_queue_top.sv
// Delta-list timer queue: up to 16 timer slots kept in deadline order, each
// storing its delay relative to the slot before it. Requests are add (0),
// remove (1) and tick (2); add and remove give one result, a tick gives one
// result per expired slot in deadline order (status 3) or a single done
// result, and last marks the final result of each request. A two-entry
// request queue feeds the list engine, which feeds a four-entry result
// queue. Add and remove walk the linked list one slot per cycle and then give
// their result; a tick gives one result per expired slot from its tick state;
// refused and unknown requests are answered from the idle state. A full result
// queue stalls the engine for as long as it stays full.
module delta_list_timer_queue_top
    import dltq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  dltq_req_t req,
    output logic      empty,
    input  logic      pop,
    output dltq_rsp_t rsp
);

    logic      cmd_valid, cmd_take, res_valid, res_full;
    dltq_cmd_t cmd;
    dltq_rsp_t res;

    dltq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    dltq_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res       (res),
        .res_full  (res_full)
    );

    dltq_result_q u_result_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_full  (res_full),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule
